@@ rtl/epoch_goodness_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// epoch_goodness_scheduler_macros
// Assertion macros shared by the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef EPOCH_GOODNESS_SCHEDULER_MACROS_SVH
`define EPOCH_GOODNESS_SCHEDULER_MACROS_SVH

// same-cycle implication, off during reset
`define EGS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define EGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/egs_pkg.sv @@
// ----------------------------------------------------------------------------
// egs_pkg
// Types and constants of the epoch goodness scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package egs_pkg;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_CURRENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_STATUS  = 2'd1,
    MODE_PRIO    = 2'd2,
    MODE_RESCHED = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_RS_RD,
    S_RS_CHG,
    S_SCAN,
    S_SCAN_END,
    S_CUR_RD,
    S_CUR_WR,
    S_BEST_RD,
    S_BEST_WR,
    S_FIN
  } state_t;

  // one process table entry
  typedef struct packed {
    status_t     status;
    logic [7:0]  base;
    logic [7:0]  eprio;
    logic [9:0]  cnt;
    logic [9:0]  quant;
    logic        late;
  } entry_t;

  localparam logic signed [19:0] BUDGET_MAX = 20'sd131071;
  localparam logic signed [19:0] BUDGET_MIN = -20'sd131072;
  localparam logic [7:0]         DEFAULT_SLICE_RST = 8'd10;

endpackage

`default_nettype wire

@@ rtl/egs_ram.sv @@
// ----------------------------------------------------------------------------
// egs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module egs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/epoch_goodness_scheduler.sv @@
// ----------------------------------------------------------------------------
// epoch_goodness_scheduler
// Process table with epoch based goodness scheduling.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per item: mode selects
// create, set status, change priority or reschedule. Every item yields one
// result word on the output channel (out_valid/out_ready).
// One item is worked on at a time; in_ready is high only while idle.
// A table update reads the entry and then writes it back. A reschedule
// reads the table RAM once per entry in a one-entry-per-cycle scan, plus
// reads and writes of the old and the new running entry around it.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, a finished item waits until the output
// register frees up.
// Reset (rst, synchronous) clears per-entry valid flags, so every entry
// reads as free and zero (entry 0 as current) without a clearing pass;
// default_slice returns to 10 and the null process runs.
// cfg_we/cfg_wdata write default_slice; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_goodness_scheduler
  import egs_pkg::*;
#(
  parameter int NUM_PROCS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [5:0] proc_index,
  input  wire logic [1:0] new_status,
  input  wire logic [7:0] priority_req,
  input  wire logic [9:0] remaining_ticks,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      next_process,
  output logic [9:0]      slice_ticks,
  output logic            epoch_started,
  output logic            was_reschedule
);

  localparam int IW = $clog2(NUM_PROCS);
  localparam int SW = IW + 10;
  localparam int EW = $bits(entry_t);

  state_t state, state_next;

  logic [7:0]    dslice;
  mode_t         r_mode;
  logic [5:0]    r_idx;
  logic [1:0]    r_status;
  logic [7:0]    r_prio;
  logic [9:0]    r_ticks;

  logic [IW-1:0] run;
  logic [17:0]   budget;
  logic          fresh;
  logic [SW-1:0] sum;
  logic [IW-1:0] best;
  logic [10:0]   best_good;
  logic [9:0]    best_cnt;
  logic [IW-1:0] scan_idx;
  logic          p_vld;
  logic [IW-1:0] p_idx;

  logic [5:0]    res_next;
  logic [9:0]    res_slice;
  logic          res_epoch;
  logic          res_resched;

  logic [NUM_PROCS-1:0] vld;
  logic          rd_vld;
  logic          rd_is0;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  entry_t        rd_ent;

  logic          idx_ok;
  logic [IW-1:0] upd_addr;

  // scan datapath
  logic [9:0]    q;
  logic [10:0]   good;
  logic          scan_use;
  logic          scan_wr;
  logic          better;

  // budget datapath
  logic signed [10:0] used;
  logic signed [19:0] b_raw;
  logic [17:0]        b_sat;

  egs_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_PROCS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // never-written entries read as their reset value
  always_comb begin
    if (rd_vld) begin
      rd_ent = entry_t'(rdata);
    end else begin
      rd_ent        = '0;
      rd_ent.status = rd_is0 ? ST_CURRENT : ST_FREE;
    end
  end

  assign idx_ok   = {26'b0, r_idx} < 32'(NUM_PROCS);
  assign upd_addr = IW'(r_idx);

  // scan of one entry
  always_comb begin
    if (rd_ent.quant == rd_ent.cnt) begin
      q = {2'b0, rd_ent.base};
    end else begin
      q = {1'b0, rd_ent.cnt[9:1]} + {2'b0, rd_ent.base};
    end
    scan_use = (rd_ent.status != ST_FREE) && !(rd_ent.late && !fresh);
    scan_wr  = p_vld && scan_use && fresh;
    if (fresh) begin
      good = {1'b0, q} + {3'b0, rd_ent.base};
    end else if (rd_ent.cnt == 10'd0) begin
      good = 11'd0;
    end else begin
      good = {1'b0, rd_ent.cnt} + {3'b0, rd_ent.eprio};
    end
    better = p_vld && scan_use && (good > best_good) &&
             ((rd_ent.status == ST_CURRENT) || (rd_ent.status == ST_READY));
  end

  // budget charge
  always_comb begin
    used  = $signed({1'b0, rd_ent.cnt}) - $signed({1'b0, r_ticks});
    b_raw = $signed({{2{budget[17]}}, budget}) - $signed({{9{used[10]}}, used});
    if (b_raw > BUDGET_MAX) begin
      b_sat = BUDGET_MAX[17:0];
    end else if (b_raw < BUDGET_MIN) begin
      b_sat = BUDGET_MIN[17:0];
    end else begin
      b_sat = b_raw[17:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (mode_t'(mode) == MODE_RESCHED) ? S_RS_RD : S_UPD_RD;
        end
      end
      S_UPD_RD:   state_next = S_UPD_WR;
      S_UPD_WR:   state_next = S_FIN;
      S_RS_RD:    state_next = S_RS_CHG;
      S_RS_CHG:   state_next = S_SCAN;
      S_SCAN: begin
        if (scan_idx == IW'(1)) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: state_next = S_CUR_RD;
      S_CUR_RD:   state_next = S_CUR_WR;
      S_CUR_WR:   state_next = S_BEST_RD;
      S_BEST_RD:  state_next = S_BEST_WR;
      S_BEST_WR:  state_next = S_FIN;
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    in_ready = (state == S_IDLE);
    we       = 1'b0;
    waddr    = run;
    wdata    = rd_ent;
    raddr    = run;
    if (scan_wr) begin
      we          = 1'b1;
      waddr       = p_idx;
      wdata       = rd_ent;
      wdata.quant = q;
      wdata.cnt   = q;
      wdata.late  = 1'b0;
      wdata.eprio = rd_ent.base;
    end
    unique case (state)
      S_UPD_RD: raddr = upd_addr;
      S_UPD_WR: begin
        waddr = upd_addr;
        unique case (r_mode)
          MODE_CREATE: begin
            wdata        = '0;
            wdata.status = ST_READY;
            wdata.base   = r_prio;
            wdata.late   = 1'b1;
            we           = idx_ok && (r_idx != 6'd0);
          end
          MODE_STATUS: begin
            wdata.status = status_t'(r_status);
            we           = idx_ok && (status_t'(r_status) != ST_CURRENT);
          end
          MODE_PRIO: begin
            wdata.base = r_prio;
            we         = idx_ok;
          end
          default: we = 1'b0;
        endcase
      end
      S_RS_CHG: begin
        we        = 1'b1;
        wdata.cnt = r_ticks;
      end
      S_SCAN:  raddr = scan_idx;
      S_CUR_WR: begin
        wdata.status = ST_READY;
        we           = (rd_ent.status == ST_CURRENT);
      end
      S_BEST_RD: raddr = best;
      S_BEST_WR: begin
        waddr        = best;
        wdata.status = ST_CURRENT;
        we           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dslice    <= DEFAULT_SLICE_RST;
      run       <= '0;
      budget    <= '0;
      vld       <= '0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        dslice <= cfg_wdata;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      p_vld <= (state == S_SCAN);
      if (state == S_RS_CHG) begin
        budget <= b_sat;
      end
      if (state == S_CUR_RD && fresh) begin
        budget <= (32'(sum) > 32'd131071) ? 18'd131071 : 18'(sum);
      end
      if (state == S_BEST_WR) begin
        run <= best;
      end
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    rd_is0 <= (raddr == '0);
    p_idx  <= scan_idx;
    if (in_valid && in_ready) begin
      r_mode   <= mode_t'(mode);
      r_idx    <= proc_index;
      r_status <= new_status;
      r_prio   <= priority_req;
      r_ticks  <= remaining_ticks;
    end
    if (state == S_RS_CHG) begin
      fresh     <= (b_raw <= 20'sd0) || (run == '0);
      scan_idx  <= IW'(NUM_PROCS - 1);
      sum       <= '0;
      best      <= '0;
      best_good <= '0;
      best_cnt  <= '0;
    end
    if (state == S_SCAN) begin
      scan_idx <= scan_idx - IW'(1);
    end
    if (scan_wr) begin
      sum <= sum + SW'(q);
    end
    if (better) begin
      best      <= p_idx;
      best_good <= good;
      best_cnt  <= fresh ? q : rd_ent.cnt;
    end
    if (state == S_UPD_WR) begin
      res_next    <= 6'(run);
      res_slice   <= '0;
      res_epoch   <= 1'b0;
      res_resched <= 1'b0;
    end
    if (state == S_BEST_WR) begin
      res_next    <= 6'(best);
      res_slice   <= (best == '0) ? {2'b0, dslice} : best_cnt;
      res_epoch   <= fresh;
      res_resched <= 1'b1;
    end
    if (state == S_FIN && (!out_valid || out_ready)) begin
      next_process   <= res_next;
      slice_ticks    <= res_slice;
      epoch_started  <= res_epoch;
      was_reschedule <= res_resched;
    end
  end

endmodule

`default_nettype wire

@@ rtl/egs_chk.sv @@
// ----------------------------------------------------------------------------
// egs_chk
// Port-level checks of the epoch goodness scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_goodness_scheduler_macros.svh"

module egs_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] next_process,
  input wire logic [9:0] slice_ticks,
  input wire logic       epoch_started,
  input wire logic       was_reschedule
);

  // an acknowledge carries no slice and no epoch flag
  `EGS_ASSERT(a_ack_clean, out_valid && !was_reschedule, slice_ticks == 10'd0 && !epoch_started, "ack word carries slice or epoch flag")

  // one item at a time: busy right after an accept
  `EGS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a word while busy")

  // a stalled result word holds
  `EGS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_process) && $stable(slice_ticks), "stalled result word changed")

  // a result never appears in the cycle after an accept
  `EGS_ASSERT_NXT(a_no_instant, in_valid && in_ready && !out_valid, !out_valid, "result without processing time")

endmodule

bind epoch_goodness_scheduler egs_chk u_egs_chk (.*);

`default_nettype wire
